[rtl/core/crsf_pkg.sv]
// shared types, constants and helper functions for the crsf frame parser
// no dependencies; imported by crsf_payload_store and the core top level
`timescale 1ns / 1ps
`default_nettype none

package crsf_pkg;

  // default payload store depth, bytes
  localparam int MAX_PAYLOAD_DEFAULT = 60;

  // width of the byte position fields and of store addresses on the request bus
  localparam int POS_W = 6;

  // reset value of the maximum frame length register
  localparam logic [5:0] MAX_LEN_RESET = 6'd62;

  // result status codes
  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_BAD_ADDR = 2'd1;
  localparam logic [1:0] ST_BAD_LEN  = 2'd2;
  localparam logic [1:0] ST_BAD_CRC  = 2'd3;

  localparam logic [7:0] CRC_POLY = 8'hD5;
  localparam logic [7:0] MSB_MASK = 8'h80;

  localparam int NUM_ADDRS = 13;
  localparam logic [7:0] DEV_ADDRS [NUM_ADDRS] = '{
    8'h00, 8'h10, 8'h80, 8'h8A, 8'hC0, 8'hC2, 8'hC4,
    8'hC8, 8'hCA, 8'hCC, 8'hEA, 8'hEC, 8'hEE
  };

  // request bus from the parser to the payload store
  typedef struct packed {
    logic             wr_en;
    logic [POS_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [POS_W-1:0] rd_addr;
  } store_req_t;

  // crc-8, msb first, one byte folded in
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((v & MSB_MASK) != 8'h00) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

  // true for one of the known device addresses
  function automatic logic addr_known(input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_ADDRS; i++) begin
      if (DEV_ADDRS[i] == b) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

[rtl/core/crsf_payload_store.sv]
// payload byte store: one write port, one registered read port
// depends on crsf_pkg for the request bus type
`timescale 1ns / 1ps
`default_nettype none

module crsf_payload_store
  import crsf_pkg::*;
#(
  parameter int DEPTH = MAX_PAYLOAD_DEFAULT
) (
  input  wire logic       clk,
  input  wire store_req_t req,
  output logic [7:0]      rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
  end

  // registered read: data appears in the cycle after the read is issued
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr[AW-1:0]];
    end
  end

endmodule

`default_nettype wire

[rtl/core/crsf_frame_parser_crc8_core.sv]
// crsf frame parser core: one received byte per transaction, crc-8 checked frames
// error and header results load at the accepting edge; payload results follow via the emit phases
// payload readout: per result a registered store read, then the output load when the slot is free
// input stalls during readout and while a waiting result blocks a byte that may make one
// reset (rst, synchronous): parser to address phase, holds cleared, max length 62
// the payload store is not cleared; entries are read only after written in the same frame
`timescale 1ns / 1ps
`default_nettype none

module crsf_frame_parser_crc8_core
  import crsf_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // byte input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  // configuration write
  input  wire logic       cfg_write,
  input  wire logic [5:0] cfg_data,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      status,
  output logic [7:0]      frame_address,
  output logic [7:0]      frame_type,
  output logic [5:0]      payload_length,
  output logic [5:0]      byte_index,
  output logic [7:0]      payload_byte,
  output logic            payload_valid,
  output logic            last
);

  // the length byte never passes 63, so at most 61 payload bytes are ever stored
  localparam int DEPTH = (MAX_PAYLOAD < 61) ? MAX_PAYLOAD : 61;
  // cap on the length byte: payload plus type and crc
  localparam logic [7:0] LIM_CAP = 8'(MAX_PAYLOAD + 2);

  // parser phases
  localparam logic [2:0] PH_ADDR    = 3'd0;
  localparam logic [2:0] PH_LEN     = 3'd1;
  localparam logic [2:0] PH_TYPE    = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CRC     = 3'd4;
  localparam logic [2:0] PH_EMIT_RD = 3'd5;  // issue store read
  localparam logic [2:0] PH_EMIT_WR = 3'd6;  // move read data to the output register

  // control state
  logic [2:0] phase, phase_next;
  logic [7:0] held_address, held_address_next;
  logic [7:0] held_type, held_type_next;
  logic [5:0] held_payload_length, held_payload_length_next;
  logic [5:0] payload_count, payload_count_next;  // write pointer, then readout index
  logic [7:0] running_crc, running_crc_next;
  logic [5:0] max_len;

  // store interface
  store_req_t req;
  logic [7:0] rd_data;

  // result being loaded into the output register this cycle
  logic       load;
  logic [1:0] res_status;
  logic [7:0] res_address;
  logic [7:0] res_type;
  logic [5:0] res_length;
  logic [5:0] res_index;
  logic [7:0] res_byte;
  logic       res_valid;
  logic       res_last;

  logic       accept;
  logic       emitting;
  logic       may_result;
  logic       out_free;
  logic [7:0] lim;
  logic [5:0] count_inc;

  crsf_payload_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .req    (req),
    .rd_data(rd_data)
  );

  assign emitting   = (phase == PH_EMIT_RD) || (phase == PH_EMIT_WR);
  // type and payload bytes never produce a result, so they pass a waiting result
  assign may_result = !((phase == PH_TYPE) || (phase == PH_PAYLOAD));
  assign in_stall   = emitting || (out_valid && may_result);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;

  // effective length limit
  assign lim       = ({2'b00, max_len} > LIM_CAP) ? LIM_CAP : {2'b00, max_len};
  assign count_inc = payload_count + 6'd1;

  always_comb begin
    phase_next               = phase;
    held_address_next        = held_address;
    held_type_next           = held_type;
    held_payload_length_next = held_payload_length;
    payload_count_next       = payload_count;
    running_crc_next         = running_crc;

    req         = '0;
    load        = 1'b0;
    res_status  = ST_GOOD;
    res_address = 8'h00;
    res_type    = 8'h00;
    res_length  = 6'd0;
    res_index   = 6'd0;
    res_byte    = 8'h00;
    res_valid   = 1'b0;
    res_last    = 1'b1;

    unique case (phase)
      PH_LEN: begin
        if (accept) begin
          if ((rx_byte < 8'd2) || (rx_byte > lim)) begin
            load        = 1'b1;
            res_status  = ST_BAD_LEN;
            res_address = held_address;
            phase_next  = PH_ADDR;
          end else begin
            // length is at most 63 here, so the low six bits carry it
            held_payload_length_next = rx_byte[5:0] - 6'd2;
            phase_next               = PH_TYPE;
          end
        end
      end
      PH_TYPE: begin
        if (accept) begin
          held_type_next     = rx_byte;
          running_crc_next   = crc8_byte(8'h00, rx_byte);
          payload_count_next = 6'd0;
          phase_next         = (held_payload_length == 6'd0) ? PH_CRC : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (accept) begin
          req.wr_en          = 1'b1;
          req.wr_addr        = payload_count;
          req.wr_data        = rx_byte;
          running_crc_next   = crc8_byte(running_crc, rx_byte);
          payload_count_next = count_inc;
          if (count_inc >= held_payload_length) begin
            phase_next = PH_CRC;
          end
        end
      end
      PH_CRC: begin
        if (accept) begin
          if (rx_byte != running_crc) begin
            load        = 1'b1;
            res_status  = ST_BAD_CRC;
            res_address = held_address;
            res_type    = held_type;
            phase_next  = PH_ADDR;
          end else if (held_payload_length == 6'd0) begin
            // empty payload: one header result
            load        = 1'b1;
            res_status  = ST_GOOD;
            res_address = held_address;
            res_type    = held_type;
            phase_next  = PH_ADDR;
          end else begin
            payload_count_next = 6'd0;
            phase_next         = PH_EMIT_RD;
          end
        end
      end
      PH_EMIT_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = payload_count;
        phase_next  = PH_EMIT_WR;
      end
      PH_EMIT_WR: begin
        // read data stays put until the next read is issued
        if (out_free) begin
          load        = 1'b1;
          res_status  = ST_GOOD;
          res_address = held_address;
          res_type    = held_type;
          res_length  = held_payload_length;
          res_index   = payload_count;
          res_byte    = rd_data;
          res_valid   = 1'b1;
          res_last    = (count_inc == held_payload_length);
          if (count_inc == held_payload_length) begin
            phase_next = PH_ADDR;
          end else begin
            payload_count_next = count_inc;
            phase_next         = PH_EMIT_RD;
          end
        end
      end
      default: begin
        // address phase; unused codes act the same
        if (accept) begin
          if (!addr_known(rx_byte)) begin
            load       = 1'b1;
            res_status = ST_BAD_ADDR;
            phase_next = PH_ADDR;
          end else begin
            held_address_next = rx_byte;
            phase_next        = PH_LEN;
          end
        end
      end
    endcase

    // every error, header or last payload result ends the frame; clear the holds for the next one
    if (phase_next == PH_ADDR) begin
      held_address_next        = 8'h00;
      held_type_next           = 8'h00;
      held_payload_length_next = 6'd0;
      payload_count_next       = 6'd0;
      running_crc_next         = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_ADDR;
      held_address        <= 8'h00;
      held_type           <= 8'h00;
      held_payload_length <= 6'd0;
      payload_count       <= 6'd0;
      running_crc         <= 8'h00;
      max_len             <= MAX_LEN_RESET;
      out_valid           <= 1'b0;
    end else begin
      phase               <= phase_next;
      held_address        <= held_address_next;
      held_type           <= held_type_next;
      held_payload_length <= held_payload_length_next;
      payload_count       <= payload_count_next;
      running_crc         <= running_crc_next;
      if (cfg_write) begin
        max_len <= cfg_data;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload register, loaded only when the slot is free
  always_ff @(posedge clk) begin
    if (load) begin
      status         <= res_status;
      frame_address  <= res_address;
      frame_type     <= res_type;
      payload_length <= res_length;
      byte_index     <= res_index;
      payload_byte   <= res_byte;
      payload_valid  <= res_valid;
      last           <= res_last;
    end
  end

endmodule

`default_nettype wire
